// ===== sv/pktc_pkg.sv =====
// ----------------------------------------------------------------------------
// pktc_pkg: shared types and constants for the per-key traffic counter table
// Command codes, slot geometry, transaction structs and the FSM state type.
// ----------------------------------------------------------------------------
package pktc_pkg;

  localparam int TABLE_SLOTS = 64;
  localparam int SLOT_W      = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int CNT_W       = SLOT_W + 1;

  typedef enum logic [1:0] {
    CMD_UPDATE = 2'd0,
    CMD_DUMP   = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] flow_key;
    logic [31:0] byte_count;
    logic        outbound;
    logic [6:0]  max_entries;
  } in_item_t;

  typedef struct packed {
    logic        entry_present;
    logic [31:0] key_out;
    logic [63:0] bytes_sent;
    logic [63:0] bytes_received;
    logic [63:0] packets_sent;
    logic [63:0] packets_received;
    logic        last;
  } out_item_t;

  // one stored slot
  typedef struct packed {
    logic [31:0] key;
    logic [63:0] bytes_sent;
    logic [63:0] bytes_received;
    logic [63:0] packets_sent;
    logic [63:0] packets_received;
  } slot_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROBE_RD,
    ST_PROBE_CHK,
    ST_DUMP_RD,
    ST_DUMP_CHK,
    ST_EMPTY
  } state_t;

endpackage

// ===== sv/per_key_traffic_counter_table.sv =====
// ----------------------------------------------------------------------------
// per_key_traffic_counter_table: per-key byte/packet counter table
// Linear-probing hash table of traffic counters held in a slot RAM.
// ----------------------------------------------------------------------------
// Channel   Ports                      Transaction
// command   start, busy, cmd_in        start && !busy
// result    res_valid, res_out         res_valid (one cycle, no backpressure)
//
// Update: each probe step is a RAM read, then a compare/write; the probe ends at
// a hit, a free slot or after all TABLE_SLOTS slots have been tried.
// Dump: each slot scanned is a RAM read, then a check; one result per occupied
// slot; the scan stops at the limit or after the last occupied slot.
// Clear and ignored commands leave the block idle (busy stays low). Valid bits
// are flip-flops cleared by rst or clear at once; no clearing pass. The receiver cannot stall.
// ----------------------------------------------------------------------------
module per_key_traffic_counter_table (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  pktc_pkg::in_item_t    cmd_in,
  output logic                  res_valid,
  output pktc_pkg::out_item_t   res_out
);

  localparam int SW = pktc_pkg::SLOT_W;
  localparam int CW = pktc_pkg::CNT_W;
  localparam int TS = pktc_pkg::TABLE_SLOTS;
  localparam int DW = $bits(pktc_pkg::slot_t);

  pktc_pkg::state_t  state, state_next;
  pktc_pkg::in_item_t req;
  logic [pktc_pkg::TABLE_SLOTS-1:0] valid;
  logic [SW-1:0] slot;
  logic [CW-1:0] steps;      // probe steps or dump slots done
  logic [CW-1:0] emitted;
  logic [CW-1:0] limit;

  logic          we;
  logic [SW-1:0] raddr;
  pktc_pkg::slot_t wdata, rdata;

  pktc_slot_ram #(.DEPTH(pktc_pkg::TABLE_SLOTS), .ADDR_W(SW), .DATA_W(DW)) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(slot),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  logic hit, free_slot, wrap_end, dump_emit, dump_end;
  logic tail_empty, last_entry;
  logic [TS-1:0] upper_mask;
  logic [SW-1:0] slot_inc;
  pktc_pkg::slot_t base;

  assign slot_inc  = (slot == SW'(pktc_pkg::TABLE_SLOTS - 1)) ? '0 : slot + 1'b1;
  assign free_slot = !valid[slot];
  assign hit       = valid[slot] && (rdata.key == req.flow_key);
  assign wrap_end  = (steps == CW'(pktc_pkg::TABLE_SLOTS - 1));
  assign dump_emit = valid[slot];
  // slots above the current one; an empty tail makes this entry the last
  assign upper_mask = ~((TS'(2) << slot) - TS'(1));
  assign tail_empty = ((valid & upper_mask) == '0);
  assign last_entry = dump_emit && ((emitted + 1'b1 == limit) || tail_empty);
  assign dump_end  = wrap_end || last_entry;
  assign raddr     = slot;
  assign busy      = (state != pktc_pkg::ST_IDLE);

  always_comb begin
    base = free_slot ? pktc_pkg::slot_t'{key: req.flow_key, default: '0} : rdata;
    wdata = base;
    if (req.outbound) begin
      wdata.bytes_sent   = base.bytes_sent + 64'(req.byte_count);
      wdata.packets_sent = base.packets_sent + 64'd1;
    end else begin
      wdata.bytes_received   = base.bytes_received + 64'(req.byte_count);
      wdata.packets_received = base.packets_received + 64'd1;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      pktc_pkg::ST_IDLE: begin
        if (start) begin
          case (pktc_pkg::cmd_t'(cmd_in.command))
            pktc_pkg::CMD_UPDATE:
              if (cmd_in.flow_key != '0 && cmd_in.byte_count != '0)
                state_next = pktc_pkg::ST_PROBE_RD;
            pktc_pkg::CMD_DUMP:
              state_next = (cmd_in.max_entries == '0) ? pktc_pkg::ST_EMPTY
                                                      : pktc_pkg::ST_DUMP_RD;
            default: state_next = pktc_pkg::ST_IDLE;
          endcase
        end
      end
      pktc_pkg::ST_PROBE_RD:  state_next = pktc_pkg::ST_PROBE_CHK;
      pktc_pkg::ST_PROBE_CHK: begin
        if (free_slot || hit || wrap_end) state_next = pktc_pkg::ST_IDLE;
        else                              state_next = pktc_pkg::ST_PROBE_RD;
      end
      pktc_pkg::ST_DUMP_RD:  state_next = pktc_pkg::ST_DUMP_CHK;
      pktc_pkg::ST_DUMP_CHK: begin
        if (dump_end)
          state_next = (emitted == '0 && !dump_emit) ? pktc_pkg::ST_EMPTY
                                                     : pktc_pkg::ST_IDLE;
        else
          state_next = pktc_pkg::ST_DUMP_RD;
      end
      pktc_pkg::ST_EMPTY: state_next = pktc_pkg::ST_IDLE;
      default: state_next = pktc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    we        = 1'b0;
    res_valid = 1'b0;
    res_out   = '0;
    case (state)
      pktc_pkg::ST_PROBE_CHK: we = free_slot || hit;
      pktc_pkg::ST_DUMP_CHK: begin
        res_valid                = dump_emit;
        res_out.entry_present    = 1'b1;
        res_out.key_out          = rdata.key;
        res_out.bytes_sent       = rdata.bytes_sent;
        res_out.bytes_received   = rdata.bytes_received;
        res_out.packets_sent     = rdata.packets_sent;
        res_out.packets_received = rdata.packets_received;
        res_out.last             = dump_end;
      end
      pktc_pkg::ST_EMPTY: begin
        res_valid    = 1'b1;
        res_out.last = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pktc_pkg::ST_IDLE;
      valid <= '0;
    end else begin
      state <= state_next;
      if (state == pktc_pkg::ST_IDLE && start &&
          pktc_pkg::cmd_t'(cmd_in.command) == pktc_pkg::CMD_CLEAR)
        valid <= '0;
      if (we) valid[slot] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      pktc_pkg::ST_IDLE: begin
        req     <= cmd_in;
        steps   <= '0;
        emitted <= '0;
        limit   <= (cmd_in.max_entries > 7'(pktc_pkg::TABLE_SLOTS))
                   ? CW'(pktc_pkg::TABLE_SLOTS) : CW'(cmd_in.max_entries);
        if (pktc_pkg::cmd_t'(cmd_in.command) == pktc_pkg::CMD_UPDATE)
          slot <= SW'(cmd_in.flow_key % pktc_pkg::TABLE_SLOTS);
        else
          slot <= '0;
      end
      pktc_pkg::ST_PROBE_CHK: begin
        slot  <= slot_inc;
        steps <= steps + 1'b1;
      end
      pktc_pkg::ST_DUMP_CHK: begin
        slot  <= slot_inc;
        steps <= steps + 1'b1;
        if (dump_emit) emitted <= emitted + 1'b1;
      end
      default: ;
    endcase
  end

endmodule

// ===== sv/pktc_slot_ram.sv =====
// ----------------------------------------------------------------------------
// pktc_slot_ram: slot storage
// Single-port-write, one-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module pktc_slot_ram #(
  parameter int DEPTH  = 64,
  parameter int ADDR_W = 6,
  parameter int DATA_W = 32
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
